>>> sv/phs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phs_pkg: shared types and constants of the pair key hash set
// Action and status codes, hash constants and the request queue entry.
// ----------------------------------------------------------------------------
package phs_pkg;

	localparam int KEY_W       = 15;
	localparam int SUM_W       = 29;
	localparam int CNT_W       = 5;
	localparam int HASH_MUL_A  = 10001;
	localparam int HASH_MUL_B  = 7;
	localparam int FULL_MARGIN = 3;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_ABSENT  = 3'd0,
		ST_PRESENT = 3'd1,
		ST_INSERTED = 3'd2,
		ST_ALREADY = 3'd3,
		ST_FULL    = 3'd4,
		ST_INVALID = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]       action;
		logic             bad_key;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
		logic [SUM_W-1:0] sum;
	} item_t;

endpackage
`default_nettype wire

>>> sv/pair_key_hash_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_key_hash_set: set of two-part keys, open addressing, linear probing
//
//  channel   ports                               handshake
//  request   start, busy, action, key_a, key_b   taken when start & !busy
//  result    status_valid, status                one-cycle strobe
//  config    cfg_valid, cfg_ready, half_capacity written when valid & ready
//
// Lookup/insert: from acceptance to the status strobe a request passes the
// intake register, the queue, a bit-serial modulo and a registered slot memory
// read and check for each probed slot. Other requests skip the modulo and probe.
// Clear sweeps all TABLE_DEPTH slots of the memory. After reset the same sweep
// runs; requests queue and busy rises once the queue and intake register fill.
// Results cannot be stalled; busy reflects only queue and intake occupancy.
// ----------------------------------------------------------------------------
module pair_key_hash_set #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] key_a,
	input  wire logic [15:0] key_b,
	output logic             status_valid,
	output logic [2:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  half_capacity
);
	import phs_pkg::*;

	logic [8:0] half_q;
	item_t      push_item;
	item_t      head;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 9'd511;
		end else if (cfg_valid && cfg_ready) begin
			half_q <= half_capacity;
		end
	end

	phs_front u_front (
		.clk, .arst_n, .start, .busy, .action, .key_a, .key_b,
		.push_item, .push, .q_full
	);

	phs_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head,
		.full(q_full), .empty(q_empty)
	);

	phs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .q_empty, .head, .pop,
		.half_capacity(half_q), .status_valid, .status
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status != 3'd7)
		else $error("undefined status code");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("request queue underflow");

endmodule
`default_nettype wire

>>> sv/phs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phs_front: request intake
// Checks key signs and forms the unreduced hash sum, one request per cycle while not busy.
// ----------------------------------------------------------------------------
module phs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [1:0]    action,
	input  wire logic [15:0]   key_a,
	input  wire logic [15:0]   key_b,
	output phs_pkg::item_t     push_item,
	output logic               push,
	input  wire logic          q_full
);
	import phs_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign busy      = valid_s1 & q_full;
	assign take      = start & ~busy;
	assign push      = valid_s1 & ~q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action  <= action;
			item_s1.bad_key <= key_a[15] | key_b[15];
			item_s1.key_a   <= key_a[KEY_W-1:0];
			item_s1.key_b   <= key_b[KEY_W-1:0];
			item_s1.sum     <= SUM_W'(key_a[KEY_W-1:0]) * SUM_W'(HASH_MUL_A)
				+ SUM_W'(key_b[KEY_W-1:0]) * SUM_W'(HASH_MUL_B);
		end
	end

endmodule
`default_nettype wire

>>> sv/phs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phs_queue: two-entry request queue
// Decouples intake from the table walk.
// ----------------------------------------------------------------------------
module phs_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  phs_pkg::item_t     push_item,
	input  wire logic          pop,
	output phs_pkg::item_t     head,
	output logic               full,
	output logic               empty
);
	import phs_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

>>> sv/phs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phs_back: table engine
// Reduces the hash modulo the active size, walks the slot memory and
// sweeps it clean after reset and on a clear request.
// ----------------------------------------------------------------------------
module phs_back #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  phs_pkg::item_t     head,
	output logic               pop,
	input  wire logic [8:0]    half_capacity,
	output logic               status_valid,
	output logic [2:0]         status
);
	import phs_pkg::*;

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int SW       = AW + 1;
	localparam int RST_SIZE = (1023 > TABLE_DEPTH) ? TABLE_DEPTH : 1023;
	localparam int ENT_W    = 1 + 2 * KEY_W;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIV, S_RD, S_CHK} state_t;

	state_t           state_q;
	item_t            item_q;
	logic [SW-1:0]    size_q;
	logic [SW-1:0]    count_q;
	logic [SW-1:0]    rem_q;
	logic [SUM_W-1:0] div_q;
	logic [CNT_W-1:0] step_q;
	logic [AW-1:0]    pos_q;
	logic [SW-1:0]    n_q;
	logic [SW-1:0]    sweep_q;
	logic             status_valid_q;
	status_t          status_q;

	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [ENT_W-1:0] rd_q;

	logic [SW:0]      trial;
	logic [SW-1:0]    rem_next;
	logic [17:0]      new_size_wide;
	logic [SW-1:0]    new_size;
	logic             hit;
	logic             hole;
	logic             room;
	logic             do_ins;
	logic [SW-1:0]    pos_next;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [ENT_W-1:0] wdata;

	assign trial = {rem_q, div_q[SUM_W-1]};
	assign rem_next = (trial >= {1'b0, size_q}) ? SW'(trial - {1'b0, size_q})
		: SW'(trial);
	assign new_size_wide = {8'd0, half_capacity, 1'b1};
	assign new_size = (new_size_wide > 18'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH)
		: SW'(new_size_wide);

	assign hole   = ~rd_q[ENT_W-1];
	assign hit    = rd_q[ENT_W-1] & (rd_q[2*KEY_W-1:KEY_W] == item_q.key_a)
		& (rd_q[KEY_W-1:0] == item_q.key_b);
	assign room   = (SW+1)'(count_q) + (SW+1)'(FULL_MARGIN) <= (SW+1)'(size_q);
	assign do_ins = (state_q == S_CHK) & hole & (item_q.action == ACT_INSERT) & room;
	assign pos_next = SW'(pos_q) + SW'(1);

	assign pop          = (state_q == S_IDLE) & ~q_empty;
	assign status_valid = status_valid_q;
	assign status       = status_q;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = {1'b1, item_q.key_a, item_q.key_b};
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = sweep_q[AW-1:0];
			wdata = '0;
		end else if (do_ins) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			size_q         <= SW'(RST_SIZE);
			count_q        <= '0;
			sweep_q        <= '0;
			status_valid_q <= 1'b0;
			status_q       <= ST_ABSENT;
			rem_q          <= '0;
			div_q          <= '0;
			step_q         <= '0;
			pos_q          <= '0;
			n_q            <= '0;
			item_q         <= '0;
		end else begin
			status_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_q == SW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						item_q <= head;
						if (head.action == ACT_CLEAR) begin
							count_q        <= '0;
							size_q         <= new_size;
							sweep_q        <= '0;
							status_valid_q <= 1'b1;
							status_q       <= ST_CLEARED;
							state_q        <= S_CLR;
						end else if (head.action != ACT_LOOKUP
							&& head.action != ACT_INSERT) begin
							status_valid_q <= 1'b1;
							status_q       <= ST_ABSENT;
						end else if (head.bad_key) begin
							status_valid_q <= 1'b1;
							status_q       <= ST_INVALID;
						end else begin
							rem_q   <= '0;
							div_q   <= head.sum;
							step_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// one quotient bit per cycle, MSB first
					div_q  <= div_q << 1;
					step_q <= step_q + CNT_W'(1);
					rem_q  <= rem_next;
					if (step_q == CNT_W'(SUM_W - 1)) begin
						// home slot is the final remainder
						pos_q   <= rem_next[AW-1:0];
						state_q <= S_RD;
						n_q     <= '0;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (hole) begin
						status_valid_q <= 1'b1;
						state_q        <= S_IDLE;
						if (item_q.action == ACT_LOOKUP) begin
							status_q <= ST_ABSENT;
						end else if (room) begin
							status_q <= ST_INSERTED;
							count_q  <= count_q + SW'(1);
						end else begin
							status_q <= ST_FULL;
						end
					end else if (hit) begin
						status_valid_q <= 1'b1;
						state_q        <= S_IDLE;
						status_q <= (item_q.action == ACT_LOOKUP) ? ST_PRESENT : ST_ALREADY;
					end else if (n_q + SW'(1) == size_q) begin
						// walked the whole table without a hole
						status_valid_q <= 1'b1;
						state_q        <= S_IDLE;
						status_q <= (item_q.action == ACT_LOOKUP) ? ST_ABSENT : ST_FULL;
					end else begin
						n_q     <= n_q + SW'(1);
						pos_q   <= (pos_next == size_q) ? '0 : pos_next[AW-1:0];
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
